// ===== design/wmf_pkg.sv =====
package wmf_pkg;

    // Store geometry and field widths.
    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 48;
    localparam int ADDR_BITS   = $clog2(MAX_WINDOW);
    localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);

    // Configuration register widths and port geometry.
    localparam int WIN_BITS      = 7;
    localparam int THR_BITS      = 30;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Register index codes, taken from paddr[2].
    localparam logic REG_IDX_WINDOW    = 1'b0;
    localparam logic REG_IDX_THRESHOLD = 1'b1;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET    = WIN_BITS'(16);
    localparam logic [THR_BITS-1:0] THRESHOLD_RESET = THR_BITS'(10000);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef struct packed {
        logic [WIN_BITS-1:0] window_length;
        logic [THR_BITS-1:0] jump_threshold;
    } cfg_t;

    // Window length as used by the datapath: zero acts as one, and anything
    // above the store depth acts as the store depth.
    function automatic logic [CNT_BITS-1:0] active_window(input logic [WIN_BITS-1:0] wl);
        logic [CNT_BITS-1:0] w;
        if (wl == '0) begin
            w = CNT_BITS'(1);
        end else if (int'(wl) > MAX_WINDOW) begin
            w = CNT_BITS'(MAX_WINDOW);
        end else begin
            w = CNT_BITS'(wl);
        end
        return w;
    endfunction

endpackage

// ===== design/windowed_min_filter_jump_detect.sv =====
// Sliding-window minimum filter with path-jump detection.
//
// Delay samples arrive as transfers on the s_ channel (valid/ready); each
// produces exactly one m_ result transfer with the running minimum and a
// path-jump flag. Window length (byte address 0) and jump threshold (byte
// address 4) are written through the APB port; the user must write them only
// while the block is idle, which it does not enforce. pready is always high.
//
// A sample that does not trigger a rescan passes from the input transfer
// through the finish state to a valid result. When the minimum ages out,
// the stored entries are read back from the sample memory one per cycle
// through its single read port in the scan state, followed by the check and
// finish states; the entries read are the filled entries in the window (at
// most 64). The block takes one item at a time: s_ready is high only while
// no item is in flight.
//
// The result sits in an output register, so a new input transfer is taken
// while an earlier result still waits; if the receiver stalls, the next item
// holds in its final step until the output register frees up. Reset clears
// the control state, restores the register defaults and sets the minimum to
// the largest positive value; the sample memory needs no clearing pass.
module windowed_min_filter_jump_detect (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wmf_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [wmf_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [wmf_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    // Sample input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [wmf_pkg::SAMPLE_BITS-1:0] s_delay_sample,
    // Result output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [wmf_pkg::SAMPLE_BITS-1:0] m_window_minimum,
    output logic                                 m_jump_flag
);

    localparam int SB = wmf_pkg::SAMPLE_BITS;
    localparam int AB = wmf_pkg::ADDR_BITS;
    localparam int CB = wmf_pkg::CNT_BITS;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_CHECK  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    wmf_pkg::cfg_t    cfg;

    state_t           state_reg,   state_next;
    logic [AB-1:0]    wp_reg,      wp_next;
    logic [CB-1:0]    fill_reg,    fill_next;
    logic [CB-1:0]    age_reg,     age_next;
    logic             has_reg,     has_next;
    wmf_pkg::sample_t run_min_reg, run_min_next;
    wmf_pkg::sample_t x_reg,       x_next;
    wmf_pkg::sample_t rescan_low_reg, rescan_low_next;
    logic [CB-1:0]    scan_idx_reg, scan_idx_next;
    logic [CB-1:0]    scan_n_reg,  scan_n_next;
    logic             pend_reg,    pend_next;
    logic             jump_reg,    jump_next;
    logic             m_valid_reg, m_valid_next;
    wmf_pkg::sample_t m_min_reg,   m_min_next;
    logic             m_jump_reg,  m_jump_next;

    logic             accept;
    logic [CB-1:0]    win;
    logic [CB-1:0]    wp_inc;
    logic [CB-1:0]    fill_acc;
    logic [CB-1:0]    age_inc;
    logic             take_new_min;
    logic [SB:0]      diff;
    logic             is_jump;
    logic             issue;
    logic             out_free;

    logic             mem_wr_en;
    logic [AB-1:0]    mem_wr_addr;
    wmf_pkg::sample_t mem_wr_data;
    wmf_pkg::sample_t mem_rd_data;

    wmf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wmf_store u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[AB-1:0]),
        .rd_data (mem_rd_data)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid & s_ready;
    assign win     = wmf_pkg::active_window(cfg.window_length);

    // Pointer and counter updates for the incoming sample.
    assign wp_inc       = CB'(wp_reg) + CB'(1);
    assign fill_acc     = (fill_reg < win) ? fill_reg + CB'(1) : fill_reg;
    assign age_inc      = age_reg + CB'(1);
    assign take_new_min = !has_reg || (s_delay_sample <= run_min_reg);

    // The rise is formed one bit wider than a sample so it cannot overflow.
    assign diff    = {rescan_low_reg[SB-1], rescan_low_reg} - {run_min_reg[SB-1], run_min_reg};
    assign is_jump = !diff[SB] && (diff[SB-1:0] > SB'(cfg.jump_threshold));

    assign issue    = (state_reg == S_SCAN) && (scan_idx_reg != scan_n_reg);
    assign out_free = !m_valid_reg || m_ready;

    // The memory write port serves the new sample on acceptance and the
    // restart entry after a jump; the two never fall in the same cycle.
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = wp_reg;
        mem_wr_data = s_delay_sample;
        if (accept) begin
            mem_wr_en = 1'b1;
        end else if ((state_reg == S_CHECK) && is_jump) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = x_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        age_next        = age_reg;
        has_next        = has_reg;
        run_min_next    = run_min_reg;
        x_next          = x_reg;
        rescan_low_next = rescan_low_reg;
        scan_idx_next   = scan_idx_reg;
        scan_n_next     = scan_n_reg;
        pend_next       = 1'b0;
        jump_next       = jump_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_min_next      = m_min_reg;
        m_jump_next     = m_jump_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    x_next    = s_delay_sample;
                    wp_next   = (wp_inc >= win) ? '0 : wp_inc[AB-1:0];
                    fill_next = fill_acc;
                    jump_next = 1'b0;
                    if (take_new_min) begin
                        run_min_next = s_delay_sample;
                        age_next     = '0;
                        has_next     = 1'b1;
                        state_next   = S_FINISH;
                    end else if (age_inc >= win) begin
                        // Minimum aged out: rescan the filled part of the window.
                        age_next        = '0;
                        scan_idx_next   = '0;
                        scan_n_next     = (fill_acc < win) ? fill_acc : win;
                        rescan_low_next = wmf_pkg::SAMPLE_MAX;
                        state_next      = S_SCAN;
                    end else begin
                        age_next   = age_inc;
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                // Reads are issued one per cycle; read data returns in the next cycle.
                pend_next = issue;
                if (issue) begin
                    scan_idx_next = scan_idx_reg + CB'(1);
                end
                if (pend_reg && (mem_rd_data < rescan_low_reg)) begin
                    rescan_low_next = mem_rd_data;
                end
                if (!issue && !pend_reg) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (is_jump) begin
                    // Restart holding only the current sample in entry zero.
                    jump_next    = 1'b1;
                    run_min_next = x_reg;
                    fill_next    = CB'(1);
                    wp_next      = (win > CB'(1)) ? AB'(1) : '0;
                end else begin
                    run_min_next = rescan_low_reg;
                end
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_min_next   = run_min_reg;
                    m_jump_next  = jump_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wp_reg      <= '0;
            fill_reg    <= '0;
            age_reg     <= '0;
            has_reg     <= 1'b0;
            run_min_reg <= wmf_pkg::SAMPLE_MAX;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            age_reg     <= age_next;
            has_reg     <= has_next;
            run_min_reg <= run_min_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg          <= x_next;
        rescan_low_reg <= rescan_low_next;
        scan_idx_reg   <= scan_idx_next;
        scan_n_reg     <= scan_n_next;
        jump_reg       <= jump_next;
        m_min_reg      <= m_min_next;
        m_jump_reg     <= m_jump_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_window_minimum = m_min_reg;
    assign m_jump_flag      = m_jump_reg;

    // An accepted sample always leaves the idle state on the next edge.
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted sample did not start processing");

    // Once a sample has been taken, the window holds at least one entry.
    a_fill_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        has_reg |-> (fill_reg != '0))
        else $error("window empty after a sample was stored");

    // The rescan never runs past the number of entries it set out to read.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (scan_idx_reg <= scan_n_reg))
        else $error("rescan index ran past its count");

    // A rescan always covers at least the sample just written.
    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |-> (scan_n_reg != '0))
        else $error("rescan finished without reading any entry");

    // A result is only loaded when the output register is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($past(state_reg) != S_FINISH || state_reg == S_FINISH))
        else $error("pending result overwritten");

endmodule

// ===== design/wmf_regs.sv =====
module wmf_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wmf_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [wmf_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [wmf_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    output wmf_pkg::cfg_t                        cfg
);

    wmf_pkg::cfg_t cfg_reg;
    wmf_pkg::cfg_t cfg_next;
    logic          wr_strobe;

    assign pready    = 1'b1;
    assign wr_strobe = psel & penable & pwrite & pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_strobe) begin
            case (paddr[2])
                wmf_pkg::REG_IDX_WINDOW: begin
                    cfg_next.window_length = pwdata[wmf_pkg::WIN_BITS-1:0];
                end
                wmf_pkg::REG_IDX_THRESHOLD: begin
                    cfg_next.jump_threshold = pwdata[wmf_pkg::THR_BITS-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_length  <= wmf_pkg::WINDOW_RESET;
            cfg_reg.jump_threshold <= wmf_pkg::THRESHOLD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[2])
            wmf_pkg::REG_IDX_WINDOW: begin
                prdata = wmf_pkg::APB_DATA_BITS'(cfg_reg.window_length);
            end
            wmf_pkg::REG_IDX_THRESHOLD: begin
                prdata = wmf_pkg::APB_DATA_BITS'(cfg_reg.jump_threshold);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/wmf_store.sv =====
module wmf_store (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [wmf_pkg::ADDR_BITS-1:0]    wr_addr,
    input  wmf_pkg::sample_t                 wr_data,
    input  logic                             rd_en,
    input  logic [wmf_pkg::ADDR_BITS-1:0]    rd_addr,
    output wmf_pkg::sample_t                 rd_data
);

    // Contents are undefined until written; the controller never reads an
    // entry ahead of its write inside the contract.
    wmf_pkg::sample_t mem [wmf_pkg::MAX_WINDOW];
    wmf_pkg::sample_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
